// ===== src/mhpq_pkg.sv =====
// Shared widths, codes and defaults for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

  // Payload widths fixed by the request and response formats.
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  // Default number of heap entries.
  localparam int DEFAULT_CAPACITY = 64;

  // Request kinds.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Value returned by an extract on an empty heap.
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  // Value returned for inserts.
  localparam logic signed [DATA_W-1:0] INSERT_VALUE = 32'sd0;

endpackage

`default_nettype wire

// ===== src/mhpq_if.sv =====
// Valid/ready channel interfaces for requests and responses of the heap queue.
`default_nettype none

interface mhpq_req_if;
  import mhpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

interface mhpq_rsp_if;
  import mhpq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   min_value;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_OUT_W-1:0]     entry_count;

  modport source (output valid, output min_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input min_value, input status, input entry_count,
                output ready);
endinterface

`default_nettype wire

// ===== src/min_heap_priority_queue.sv =====
// Top level of the binary min-heap priority queue with its sift sequencer.
//
//  Channel | Direction | Payload                                 | Transaction when
//  --------+-----------+-----------------------------------------+-----------------------
//  req     | in        | req_type, value                         | req.valid && req.ready
//  rsp     | out       | min_value, status, entry_count          | rsp.valid && rsp.ready
//
// An insert climbs one level at a time from acceptance to response, stopping when the
// new value is no smaller than its parent or reaches the root; each level is
// one read of the parent from the entry RAM and one compare-and-write.
// An extract reads the root, then the last entry, then walks the moved entry down
// until it settles at a leaf or above its children; each level reads both
// children from the single RAM read port, then compares and writes. Extracting the
// last entry skips the walk. Full-heap inserts and empty-heap extracts skip the RAM.
// Reset (synchronous, active high) empties the heap; the entry RAM is not cleared.
// A request is taken again once the response has moved to the output register,
// so a stalled response holds back at most the request after it.
`default_nettype none

module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
  input wire logic clk,
  input wire logic rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_EX_LOAD,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  state_t                   state;
  logic [AW-1:0]            pos;
  logic signed [DATA_W-1:0] cur;
  logic [CW-1:0]            count;
  logic signed [DATA_W-1:0] best_val;
  logic [AW-1:0]            best_idx;
  logic                     rc_ok;
  logic signed [DATA_W-1:0] res_value;
  logic [STATUS_W-1:0]      res_status;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic signed [DATA_W-1:0] cmp_a;
  logic signed [DATA_W-1:0] cmp_b;
  logic                     lt;

  logic [AW-1:0]            parent_ix;
  logic [IW-1:0]            lc_ix;
  logic [IW-1:0]            rc_ix;
  logic [IW-1:0]            count_ix;
  logic                     lc_valid;
  logic                     rc_valid;
  logic                     rc_take;
  logic                     req_xfer;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  assign req.ready = (state == ST_IDLE);
  assign req_xfer  = req.valid && req.ready;

  // Tree neighbors of the current position.
  assign parent_ix = AW'((pos - 1'b1) >> 1);
  assign lc_ix     = IW'({pos, 1'b1});
  assign rc_ix     = lc_ix + 1'b1;
  assign count_ix  = IW'(count);
  assign lc_valid  = lc_ix < count_ix;
  assign rc_valid  = rc_ix < count_ix;
  assign rc_take   = rc_ok && lt;

  assign count_wide = (CW + COUNT_OUT_W)'(count);

  // Shared signed comparator; operands follow the sequencer step.
  always_comb begin
    case (state)
      ST_UP_CMP: begin
        cmp_a = cur;
        cmp_b = mem_rdata;
      end
      ST_DN_R: begin
        cmp_a = mem_rdata;
        cmp_b = cur;
      end
      ST_DN_CMP: begin
        cmp_a = mem_rdata;
        cmp_b = best_val;
      end
      default: begin
        cmp_a = cur;
        cmp_b = mem_rdata;
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;

  // Read address for each step.
  always_comb begin
    case (state)
      ST_EX_ROOT: mem_raddr = '0;
      ST_EX_LAST: mem_raddr = AW'(count - 1'b1);
      ST_UP_CHK:  mem_raddr = parent_ix;
      ST_DN_L:    mem_raddr = AW'(lc_ix);
      ST_DN_R:    mem_raddr = AW'(rc_ix);
      default:    mem_raddr = '0;
    endcase
  end

  // Write port: the hole at pos takes either a moved neighbor or the sifted value.
  always_comb begin
    mem_waddr = pos;
    mem_wdata = cur;
    mem_we    = 1'b0;
    case (state)
      ST_UP_CHK: begin
        mem_we = (pos == '0);
      end
      ST_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = lt ? mem_rdata : cur;
      end
      ST_DN_L: begin
        mem_we = !lc_valid;
      end
      ST_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = rc_take ? mem_rdata : best_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer state and registered response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // The finish step loads the output register itself, so it owns valid then.
      if (rsp.valid && rsp.ready && state != ST_FIN) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            if (req.req_type == REQ_INSERT) begin
              res_value <= INSERT_VALUE;
              if (count == CAP_CNT) begin
                res_status <= STAT_FULL;
                state      <= ST_FIN;
              end else begin
                res_status <= STAT_OK;
                cur        <= req.value;
                pos        <= AW'(count);
                count      <= count + 1'b1;
                state      <= ST_UP_CHK;
              end
            end else begin
              if (count == '0) begin
                res_value  <= EMPTY_VALUE;
                res_status <= STAT_EMPTY;
                state      <= ST_FIN;
              end else begin
                res_status <= STAT_OK;
                state      <= ST_EX_ROOT;
              end
            end
          end
        end
        ST_UP_CHK: begin
          state <= (pos == '0) ? ST_FIN : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (lt) begin
            pos   <= parent_ix;
            state <= ST_UP_CHK;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_EX_ROOT: begin
          state <= ST_EX_LAST;
        end
        ST_EX_LAST: begin
          // Root read data arrives now; the last entry is read in this cycle.
          res_value <= mem_rdata;
          count     <= count - 1'b1;
          state     <= (count == CW'(1)) ? ST_FIN : ST_EX_LOAD;
        end
        ST_EX_LOAD: begin
          cur   <= mem_rdata;
          pos   <= '0;
          state <= ST_DN_L;
        end
        ST_DN_L: begin
          state <= lc_valid ? ST_DN_R : ST_FIN;
        end
        ST_DN_R: begin
          // Left child data is here; keep the smaller of it and the sifted value.
          best_val <= lt ? mem_rdata : cur;
          best_idx <= lt ? AW'(lc_ix) : pos;
          rc_ok    <= rc_valid;
          state    <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (rc_take) begin
            pos   <= AW'(rc_ix);
            state <= ST_DN_L;
          end else if (best_idx != pos) begin
            pos   <= best_idx;
            state <= ST_DN_L;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.min_value   <= res_value;
            rsp.status      <= res_status;
            rsp.entry_count <= count_wide[COUNT_OUT_W-1:0];
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("heap fill count exceeds capacity");

  // An insert into a heap with room grows the fill count by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.req_type == REQ_INSERT && count != CAP_CNT)
      |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the fill count");

  // An empty response carries the empty marker and an empty heap.
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_EMPTY)
      |-> (rsp.min_value == EMPTY_VALUE && rsp.entry_count == '0))
    else $error("empty response with wrong value or count");

  // The entry RAM is written only while a request is being worked on.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_IDLE && state != ST_FIN))
    else $error("entry RAM written outside a sift");

endmodule

`default_nettype wire

// ===== src/mhpq_ram.sv =====
// Heap entry storage: one write port and one registered read port.
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = mhpq_pkg::DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]                    raddr,
  output      logic signed [mhpq_pkg::DATA_W-1:0] rdata
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/min_heap_priority_queue_test.sv =====
// Self-checking testbench for the min-heap priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module min_heap_priority_queue_test;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH   = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int BACKLOG_AT   = 500;
  localparam int BACKLOG_LEN  = 300;
  localparam int IDLE_PCT     = 14;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // One response transaction as the block reports it.
  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } heap_result_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] val;
    bit                       typed;
    heap_result_t             known;
  } directed_row_t;

  // Traffic shapes of the random part.
  typedef enum int {
    PHASE_FILL,
    PHASE_MIX_UP,
    PHASE_DRAIN,
    PHASE_MIX_DOWN
  } traffic_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  min_heap_priority_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the heap contents and fill level.
  logic signed [DATA_W-1:0] shadow_heap [HEAP_DEPTH];
  int                       shadow_fill = 0;

  heap_result_t   awaited_results [$];
  directed_row_t  directed_rows [$];
  int             mismatch_count = 0;
  int             sent_count = 0;
  int             cycle_count = 0;
  bit             quiet = 1'b0;

  always #5 clk = ~clk;

  // Applies one request to the shadow heap and returns the response it must produce.
  function automatic heap_result_t heap_apply(input logic kind,
                                              input logic signed [DATA_W-1:0] val);
    heap_result_t             r;
    int                       pos;
    int                       parent;
    int                       left;
    int                       right;
    int                       best;
    logic signed [DATA_W-1:0] tmp;
    r.min_value = INSERT_VALUE;
    r.status    = STAT_OK;
    if (kind == REQ_INSERT) begin
      if (shadow_fill >= HEAP_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        shadow_heap[shadow_fill] = val;
        pos = shadow_fill;
        shadow_fill++;
        // Climb while the parent is strictly larger.
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (!(shadow_heap[pos] < shadow_heap[parent])) break;
          tmp = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[parent];
          shadow_heap[parent] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        r.min_value = EMPTY_VALUE;
        r.status    = STAT_EMPTY;
      end else begin
        r.min_value = shadow_heap[0];
        shadow_fill--;
        if (shadow_fill > 0) begin
          shadow_heap[0] = shadow_heap[shadow_fill];
          pos = 0;
          // Sink toward the smaller child; the left child wins a tie.
          forever begin
            left  = 2 * pos + 1;
            right = 2 * pos + 2;
            best  = pos;
            if (left < shadow_fill && shadow_heap[left] < shadow_heap[best]) best = left;
            if (right < shadow_fill && shadow_heap[right] < shadow_heap[best]) best = right;
            if (best == pos) break;
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = tmp;
            pos = best;
          end
        end
      end
    end
    r.entry_count = shadow_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic heap_result_t known_result(input logic signed [DATA_W-1:0] v,
                                                input logic [STATUS_W-1:0] s,
                                                input int c);
    heap_result_t r;
    r.min_value   = v;
    r.status      = s;
    r.entry_count = c[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic kind, input logic signed [DATA_W-1:0] val,
                         input bit typed, input heap_result_t known);
    directed_row_t row;
    row.kind  = kind;
    row.val   = val;
    row.typed = typed;
    row.known = known;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Mix of extremes, small values that collide often, and full-range values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int small_val;
    small_val = $urandom_range(8);
    case ($urandom_range(9))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2, 3, 4: return small_val - 4;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request transaction and records its expected response on acceptance.
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] val,
                              input bit typed, input heap_result_t known);
    heap_result_t predicted;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = heap_apply(kind, val);
    awaited_results.insert(awaited_results.size(), typed ? known : predicted);
    sent_count++;
  endtask

  // Response side: random back-pressure plus one long hold-off to fill the block.
  initial begin : response_sink
    bit backlog_done;
    backlog_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!backlog_done && sent_count >= BACKLOG_AT) begin
        backlog_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (BACKLOG_LEN) @(negedge clk);
      end
      rsp_ch.ready <= !rst && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each response transaction with the oldest expectation.
  always @(posedge clk) begin : response_check
    heap_result_t want;
    heap_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.min_value   = rsp_ch.min_value;
      got.status      = rsp_ch.status;
      got.entry_count = rsp_ch.entry_count;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected response: min_value %0d status %0d entry_count %0d",
                   got.min_value, got.status, got.entry_count);
      end else begin
        want = awaited_results.pop_front();
        if (got.min_value !== want.min_value || got.status !== want.status ||
            got.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.min_value, want.status, want.entry_count,
                     got.min_value, got.status, got.entry_count);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    traffic_phase_t           phase;
    int                       phase_left;
    int                       insert_pct;
    int                       random_done;
    logic                     kind;
    logic signed [DATA_W-1:0] val;

    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.value    = '0;

    // Directed table: empty extracts, extremes, last-entry extract, duplicates.
    add_row(REQ_EXTRACT, 32'sd0, 1'b1, known_result(EMPTY_VALUE, STAT_EMPTY, 0));
    add_row(REQ_INSERT, VALUE_MAX, 1'b1, known_result(INSERT_VALUE, STAT_OK, 1));
    add_row(REQ_INSERT, VALUE_MIN, 1'b1, known_result(INSERT_VALUE, STAT_OK, 2));
    add_row(REQ_EXTRACT, -32'sd1, 1'b1, known_result(VALUE_MIN, STAT_OK, 1));
    add_row(REQ_EXTRACT, VALUE_MAX, 1'b1, known_result(VALUE_MAX, STAT_OK, 0));
    add_row(REQ_EXTRACT, VALUE_MIN, 1'b1, known_result(EMPTY_VALUE, STAT_EMPTY, 0));
    add_row(REQ_INSERT, 32'sd0, 1'b1, known_result(INSERT_VALUE, STAT_OK, 1));
    add_row(REQ_INSERT, -32'sd1, 1'b0, '0);
    add_row(REQ_INSERT, 32'sd5, 1'b0, '0);
    add_row(REQ_INSERT, 32'sd5, 1'b0, '0);
    add_row(REQ_INSERT, -32'sd1, 1'b0, '0);
    add_row(REQ_INSERT, 32'sh5555_5555, 1'b0, '0);
    add_row(REQ_INSERT, 32'shAAAA_AAAA, 1'b0, '0);
    add_row(REQ_INSERT, 32'sd3, 1'b0, '0);
    add_row(REQ_INSERT, -32'sd7, 1'b0, '0);
    repeat (9) add_row(REQ_EXTRACT, 32'shFFFF_FFFF, 1'b0, '0);
    add_row(REQ_EXTRACT, 32'sh1234_5678, 1'b1, known_result(EMPTY_VALUE, STAT_EMPTY, 0));

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].val, directed_rows[i].typed,
                   directed_rows[i].known);

    // Random part: fill to capacity, mix, drain past empty, mix, and so on.
    phase       = PHASE_MIX_DOWN;
    phase_left  = 0;
    insert_pct  = 50;
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(130, 75);
        case (phase)
          PHASE_FILL: begin
            phase = PHASE_MIX_UP;
            insert_pct = 50;
          end
          PHASE_MIX_UP: begin
            phase = PHASE_DRAIN;
            insert_pct = 5;
          end
          PHASE_DRAIN: begin
            phase = PHASE_MIX_DOWN;
            insert_pct = 50;
          end
          default: begin
            phase = PHASE_FILL;
            insert_pct = 95;
          end
        endcase
      end
      kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT;
      val  = (kind == REQ_INSERT) ? pick_value() : $urandom;
      quiet = (random_done >= 900 && random_done < 1100);
      send_request(kind, val, 1'b0, '0);
      phase_left--;
      random_done++;
    end
    quiet = 1'b0;

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Wait for every response, then keep watching for stray ones.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== min_heap_priority_queue.f =====
src/mhpq_pkg.sv
src/mhpq_if.sv
src/mhpq_ram.sv
src/min_heap_priority_queue.sv
tb/min_heap_priority_queue_test.sv
